/* rtl/rotate_xor_decrypt_hint_matcher_defines.svh */
// Assertion macros used by the block's top module.
`ifndef ROTATE_XOR_DECRYPT_HINT_MATCHER_DEFINES_SVH
`define ROTATE_XOR_DECRYPT_HINT_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RXHM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RXHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/rxhm_pkg.sv */
package rxhm_pkg;

    localparam int MAX_HINT_BYTES = 16;
    localparam int HINT_REG_BYTES = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROTATE_AMOUNT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_XOR_KEY         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HINT_LENGTH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HINT_BYTES_LOW  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HINT_BYTES_HIGH = 3'd4;

    typedef struct packed {
        logic [2:0]                          rotate_amount;
        logic [7:0]                          xor_key;
        logic [4:0]                          hint_length;
        logic [MAX_HINT_BYTES-1:0]           use_mask;
        logic [MAX_HINT_BYTES-1:0][7:0]      expect_bytes;
    } cfg_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] amt);
        logic [15:0] twice;
        twice = {v, v} << amt;
        return twice[15:8];
    endfunction

endpackage

/* rtl/rxhm_if.sv */
interface rxhm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] cipher_byte;
    logic       end_of_buffer;

    modport source (output valid, output cipher_byte, output end_of_buffer, input ready);
    modport sink (input valid, input cipher_byte, input end_of_buffer, output ready);
endinterface

interface rxhm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] plain_byte;
    logic       hint_found;
    logic       buffer_done;

    modport source (output valid, output plain_byte, output hint_found, output buffer_done,
                    input ready);
    modport sink (input valid, input plain_byte, input hint_found, input buffer_done,
                  output ready);
endinterface

interface rxhm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rxhm_pkg::CFG_INDEX_W-1:0]  index;
    logic [rxhm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/rxhm_cfg_regs.sv */
module rxhm_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    rxhm_cfg_if.sink         cfg,
    output rxhm_pkg::cfg_t   cfg_out
);
    import rxhm_pkg::*;

    logic [2:0]  rotate_reg,  rotate_next;
    logic [7:0]  key_reg,     key_next;
    logic [4:0]  len_reg,     len_next;
    logic [63:0] hint_lo_reg, hint_lo_next;
    logic [63:0] hint_hi_reg, hint_hi_next;

    logic [HINT_REG_BYTES-1:0][7:0] hint_bytes;
    logic [4:0]                     len_clamped;
    logic [4:0]                     hint_idx [MAX_HINT_BYTES];

    assign cfg.ready  = 1'b1;
    assign hint_bytes = {hint_hi_reg, hint_lo_reg};

    always_comb
    begin
        rotate_next  = rotate_reg;
        key_next     = key_reg;
        len_next     = len_reg;
        hint_lo_next = hint_lo_reg;
        hint_hi_next = hint_hi_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ROTATE_AMOUNT:   rotate_next  = cfg.data[2:0];
                CFG_XOR_KEY:         key_next     = cfg.data[7:0];
                CFG_HINT_LENGTH:     len_next     = cfg.data[4:0];
                CFG_HINT_BYTES_LOW:  hint_lo_next = cfg.data;
                CFG_HINT_BYTES_HIGH: hint_hi_next = cfg.data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotate_reg  <= 3'd1;
            key_reg     <= 8'd0;
            len_reg     <= 5'd0;
            hint_lo_reg <= 64'd0;
            hint_hi_reg <= 64'd0;
        end
        else
        begin
            rotate_reg  <= rotate_next;
            key_reg     <= key_next;
            len_reg     <= len_next;
            hint_lo_reg <= hint_lo_next;
            hint_hi_reg <= hint_hi_next;
        end
    end

    // align the hint so that cell k sees the byte its window slot must hold
    always_comb
    begin
        len_clamped = (len_reg > 5'(MAX_HINT_BYTES)) ? 5'(MAX_HINT_BYTES) : len_reg;
        cfg_out.rotate_amount = rotate_reg;
        cfg_out.xor_key       = key_reg;
        cfg_out.hint_length   = len_clamped;
        for (int k = 0; k < MAX_HINT_BYTES; k++)
        begin
            hint_idx[k]            = len_clamped - 5'(k) - 5'd1;
            cfg_out.use_mask[k]    = 5'(k) < len_clamped;
            cfg_out.expect_bytes[k] = (hint_idx[k] < 5'(HINT_REG_BYTES))
                                      ? hint_bytes[hint_idx[k][3:0]] : 8'd0;
        end
    end

endmodule

/* rtl/rxhm_cell.sv */
module rxhm_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rxhm_pkg::cell_ctl_t  ctl,
    input  logic [7:0]           byte_in,
    input  logic                 valid_in,
    input  logic                 use_cell,
    input  logic [7:0]           expect_byte,
    output logic [7:0]           byte_out,
    output logic                 valid_out,
    output logic                 hit
);
    import rxhm_pkg::*;

    logic [7:0] byte_reg,  byte_next;
    logic       valid_reg, valid_next;

    // compare against the byte this slot takes on the current beat
    assign hit = !use_cell || (valid_in && (byte_in == expect_byte));

    always_comb
    begin
        byte_next  = byte_reg;
        valid_next = valid_reg;
        if (ctl.shift)
        begin
            byte_next  = byte_in;
            valid_next = valid_in && !ctl.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

/* rtl/rotate_xor_decrypt_hint_matcher.sv */
// Rotate-XOR byte decryptor with hint search.
//
// stream_in carries one cipher byte per beat with an end_of_buffer mark.
// Each byte is rotated left by rotate_amount, XORed with xor_key, and
// returned on stream_out together with a sticky hint_found flag and a copy
// of the mark (buffer_done). A row of sixteen window cells shifts the newest
// decrypted bytes along; every cell compares its new byte with its aligned
// hint byte, and the AND of all cells is the match of this beat.
// An accepted input beat reaches the output register in the next cycle.
// One beat per cycle without a stall; the output register is the only stage.
// A stalled receiver holds the output register; stream_in.ready drops only
// while a result waits and stream_out.ready is low.
// cfg writes (index 0..4) are always ready and take effect once registered;
// write only while the block is idle. Indices above 4 are ignored.
// Reset: rotate_amount 1, other registers 0, window empty, flag clear,
// no output pending. The beat marked end_of_buffer clears window and flag
// for the next buffer after reporting its own result.
`include "rotate_xor_decrypt_hint_matcher_defines.svh"

module rotate_xor_decrypt_hint_matcher (
    input  logic        clk,
    input  logic        rst_n,
    rxhm_in_if.sink     stream_in,
    rxhm_out_if.source  stream_out,
    rxhm_cfg_if.sink    cfg
);
    import rxhm_pkg::*;

    cfg_t       cfg_q;
    cell_ctl_t  ctl;
    logic       accept;
    logic [7:0] plain;
    logic       match;

    logic [MAX_HINT_BYTES-1:0][7:0] cell_byte;
    logic [MAX_HINT_BYTES-1:0]      cell_valid;
    logic [MAX_HINT_BYTES-1:0]      cell_hit;

    logic       found_reg,     found_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_plain_reg, out_plain_next;
    logic       out_found_reg, out_found_next;
    logic       out_done_reg,  out_done_next;

    rxhm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_q)
    );

    assign stream_in.ready = !out_valid_reg || stream_out.ready;
    assign accept          = stream_in.valid && stream_in.ready;
    assign plain           = rotl8(stream_in.cipher_byte, cfg_q.rotate_amount) ^ cfg_q.xor_key;
    assign ctl.shift       = accept;
    assign ctl.clear       = stream_in.end_of_buffer;

    for (genvar k = 0; k < MAX_HINT_BYTES; k++)
    begin : g_cell
        logic [7:0] byte_in;
        logic       valid_in;
        if (k == 0)
        begin : g_head
            assign byte_in  = plain;
            assign valid_in = 1'b1;
        end
        else
        begin : g_body
            assign byte_in  = cell_byte[k-1];
            assign valid_in = cell_valid[k-1];
        end
        rxhm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .byte_in     (byte_in),
            .valid_in    (valid_in),
            .use_cell    (cfg_q.use_mask[k]),
            .expect_byte (cfg_q.expect_bytes[k]),
            .byte_out    (cell_byte[k]),
            .valid_out   (cell_valid[k]),
            .hit         (cell_hit[k])
        );
    end

    assign match = &cell_hit;

    always_comb
    begin
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_plain_next = out_plain_reg;
        out_found_next = out_found_reg;
        out_done_next  = out_done_reg;
        if (stream_out.ready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_plain_next = plain;
            out_found_next = found_reg || match;
            out_done_next  = stream_in.end_of_buffer;
            found_next     = (found_reg || match) && !stream_in.end_of_buffer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_plain_reg <= out_plain_next;
        out_found_reg <= out_found_next;
        out_done_reg  <= out_done_next;
    end

    assign stream_out.valid       = out_valid_reg;
    assign stream_out.plain_byte  = out_plain_reg;
    assign stream_out.hint_found  = out_found_reg;
    assign stream_out.buffer_done = out_done_reg;

    `RXHM_ASSERT_NEXT(a_clear_on_last, clk, rst_n, accept && stream_in.end_of_buffer, !found_reg)
    `RXHM_ASSERT_NEXT(a_beat_lands, clk, rst_n, accept, out_valid_reg)
    `RXHM_ASSERT_IMPL(a_stall_blocks, clk, rst_n, out_valid_reg && !stream_out.ready, !stream_in.ready)
    `RXHM_ASSERT_NEXT(a_empty_hint, clk, rst_n, accept && (cfg_q.hint_length == 5'd0), out_found_reg)
    `RXHM_ASSERT_NEXT(a_head_valid, clk, rst_n, accept && !stream_in.end_of_buffer, cell_valid[0])

endmodule

/* verif/tb_rotate_xor_decrypt_hint_matcher.sv */
`timescale 1ns / 1ps

module tb_rotate_xor_decrypt_hint_matcher;

    import rxhm_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] plain;
        logic       found;
        logic       done;
    } plain_result_t;

    class decrypt_scoreboard;
        logic [2:0]  rot;
        logic [7:0]  key;
        logic [4:0]  hint_len;
        logic [63:0] hint_lo;
        logic [63:0] hint_hi;
        logic [7:0]  recent [MAX_HINT_BYTES];
        int unsigned seen;
        bit          found;
        plain_result_t expected_q[$];
        int          errors;

        function new();
            rot = 3'd1;
            key = 8'h00;
            hint_len = 5'd0;
            hint_lo = '0;
            hint_hi = '0;
            foreach (recent[i])
                recent[i] = 8'h00;
            seen = 0;
            found = 1'b0;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROTATE_AMOUNT:   rot = data[2:0];
                CFG_XOR_KEY:         key = data[7:0];
                CFG_HINT_LENGTH:     hint_len = data[4:0];
                CFG_HINT_BYTES_LOW:  hint_lo = data;
                CFG_HINT_BYTES_HIGH: hint_hi = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] hint_byte(int unsigned j);
            if (j < 8)
                return hint_lo[8*j +: 8];
            else if (j < 16)
                return hint_hi[8*(j-8) +: 8];
            return 8'h00;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_byte(logic [7:0] cipher, logic last);
            logic [7:0]    plain;
            int unsigned   span;
            bit            hit;
            plain_result_t r;
            plain = ((cipher << rot) | (cipher >> (4'd8 - rot))) ^ key;
            for (int i = MAX_HINT_BYTES - 1; i > 0; i--)
                recent[i] = recent[i-1];
            recent[0] = plain;
            if (seen < MAX_HINT_BYTES)
                seen++;
            span = (hint_len > MAX_HINT_BYTES) ? MAX_HINT_BYTES : hint_len;
            hit = (seen >= span);
            for (int unsigned i = 0; i < span; i++)
                if (recent[span-1-i] != hint_byte(i))
                    hit = 1'b0;
            if (hit)
                found = 1'b1;
            r.plain = plain;
            r.found = found;
            r.done = last;
            expected_q.push_back(r);
            if (last)
            begin
                foreach (recent[i])
                    recent[i] = 8'h00;
                seen = 0;
                found = 1'b0;
            end
        endfunction

        function void check_result(logic [7:0] got_plain, logic got_found, logic got_done);
            plain_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected beat: plain %02h found %0b done %0b",
                             got_plain, got_found, got_done);
                return;
            end
            want = expected_q.pop_front();
            if (want.plain !== got_plain || want.found !== got_found || want.done !== got_done)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch: expected plain %02h found %0b done %0b, got plain %02h found %0b done %0b",
                             want.plain, want.found, want.done, got_plain, got_found, got_done);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rxhm_in_if  cipher_if ();
    rxhm_out_if plain_if ();
    rxhm_cfg_if cfg_if ();

    rotate_xor_decrypt_hint_matcher dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream_in  (cipher_if),
        .stream_out (plain_if),
        .cfg        (cfg_if)
    );

    decrypt_scoreboard plain_check = new();

    logic [7:0] hint_plain [MAX_HINT_BYTES];
    logic [2:0] cur_rot;
    logic [7:0] cur_key;
    logic [4:0] cur_len;
    bit         narrow;
    logic [7:0] alphabet_base;
    int         burst_left;
    int         random_sent;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("tb_rotate_xor_decrypt_hint_matcher: FAIL");
        $finish;
    end

    function automatic logic [7:0] encrypt_byte(logic [7:0] plain, logic [2:0] r, logic [7:0] k);
        logic [7:0] x;
        x = plain ^ k;
        return (x >> r) | (x << (4'd8 - r));
    endfunction

    function automatic logic [7:0] pick_plain();
        if (narrow)
            return alphabet_base + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                cipher_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        cipher_if.valid <= 1'b1;
        cipher_if.cipher_byte <= c;
        cipher_if.end_of_buffer <= last;
        do
            @(posedge clk);
        while (!cipher_if.ready);
        plain_check.note_byte(c, last);
    endtask

    task automatic drain();
        cipher_if.valid <= 1'b0;
        while (plain_check.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        plain_check.set_register(idx, data);
    endtask

    task automatic apply_setting(input logic [2:0] r, input logic [7:0] k, input logic [4:0] len,
                                 input bit with_junk);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] noise;
        for (int j = 0; j < 8; j++)
        begin
            lo[8*j +: 8] = hint_plain[j];
            hi[8*j +: 8] = hint_plain[j+8];
        end
        noise = with_junk ? {$urandom(), $urandom()} : 64'd0;
        cur_rot = r;
        cur_key = k;
        cur_len = len;
        write_reg(CFG_ROTATE_AMOUNT, {noise[63:3], r});
        write_reg(CFG_XOR_KEY, {noise[63:8], k});
        write_reg(CFG_HINT_LENGTH, {noise[63:5], len});
        write_reg(CFG_HINT_BYTES_LOW, lo);
        write_reg(CFG_HINT_BYTES_HIGH, hi);
        if (with_junk)
            write_reg(CFG_INDEX_W'($urandom_range(CFG_HINT_BYTES_HIGH + 1, (1 << CFG_INDEX_W) - 1)),
                      {$urandom(), $urandom()});
        cfg_if.valid <= 1'b0;
    endtask

    task automatic random_setting();
        logic [2:0] r;
        logic [7:0] k;
        logic [4:0] len;
        case ($urandom_range(0, 3))
            0: r = 3'd0;
            1: r = 3'd7;
            default: r = 3'($urandom_range(0, 7));
        endcase
        case ($urandom_range(0, 3))
            0: k = 8'h00;
            1: k = 8'hFF;
            default: k = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 7))
            0: len = 5'd0;
            1: len = 5'd1;
            2: len = 5'd16;
            3: len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(2, 15));
        endcase
        narrow = ($urandom_range(0, 2) == 0);
        alphabet_base = 8'($urandom_range(0, 253));
        for (int i = 0; i < MAX_HINT_BYTES; i++)
            hint_plain[i] = pick_plain();
        apply_setting(r, k, len, $urandom_range(0, 1));
    endtask

    task automatic stream_buffers(input int n);
        logic [7:0] plain_buf [64];
        int blen;
        int kind;
        int span;
        int pos;
        int cut;
        int sent;
        bit last;
        sent = 0;
        while (sent < n)
        begin
            blen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            for (int i = 0; i < blen; i++)
                plain_buf[i] = pick_plain();
            span = (cur_len > MAX_HINT_BYTES) ? MAX_HINT_BYTES : cur_len;
            kind = $urandom_range(0, 9);
            if (kind < 8 && span > 0 && span <= blen)
            begin
                pos = $urandom_range(0, blen - span);
                cut = (kind < 5) ? span : $urandom_range(0, span - 1);
                for (int i = 0; i < cut; i++)
                    plain_buf[pos+i] = hint_plain[i];
                if (cut < span)
                    plain_buf[pos+cut] = hint_plain[cut] ^ 8'($urandom_range(1, 255));
            end
            for (int i = 0; i < blen; i++)
            begin
                last = (i == blen - 1) && ($urandom_range(0, 7) != 0);
                send_item(encrypt_byte(plain_buf[i], cur_rot, cur_key), last);
            end
            sent += blen;
        end
        random_sent += sent;
    endtask

    initial
    begin : receiver
        int mode;
        int left;
        int unsigned tick;
        mode = 0;
        left = 0;
        tick = 0;
        plain_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (plain_if.valid && plain_if.ready)
                plain_check.check_result(plain_if.plain_byte, plain_if.hint_found,
                                         plain_if.buffer_done);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            tick++;
            case (mode)
                0: plain_if.ready <= 1'b1;
                1: plain_if.ready <= ($urandom_range(0, 3) != 0);
                2: plain_if.ready <= (tick % 5 != 0);
                default: plain_if.ready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    initial
    begin : stimulus
        cipher_if.valid <= 1'b0;
        cipher_if.cipher_byte <= 8'h00;
        cipher_if.end_of_buffer <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_ROTATE_AMOUNT;
        cfg_if.data <= '0;
        rst_n <= 1'b0;
        burst_left = 0;
        random_sent = 0;
        narrow = 1'b0;
        alphabet_base = 8'h00;
        cur_rot = 3'd1;
        cur_key = 8'h00;
        cur_len = 5'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty hint matches on the first byte of each buffer
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b1);
        send_item(8'h01, 1'b1);
        drain();

        // over-long hint length acts as full sixteen bytes
        for (int i = 0; i < MAX_HINT_BYTES; i++)
            hint_plain[i] = 8'($urandom_range(0, 255));
        apply_setting(3'd7, 8'hFF, 5'd31, 1'b0);
        for (int i = 0; i < MAX_HINT_BYTES; i++)
            send_item(encrypt_byte(hint_plain[i], 3'd7, 8'hFF), i == MAX_HINT_BYTES - 1);
        drain();

        // one-byte hint; flag must clear after the closing byte
        hint_plain[0] = 8'hA5;
        apply_setting(3'd0, 8'h00, 5'd1, 1'b1);
        send_item(8'hA5, 1'b1);
        send_item(8'h5A, 1'b1);
        drain();

        while (random_sent < RANDOM_ITEMS)
        begin
            random_setting();
            stream_buffers($urandom_range(60, 200));
            drain();
        end

        if (plain_check.errors == 0 && plain_check.pending() == 0)
            $display("tb_rotate_xor_decrypt_hint_matcher: PASS");
        else
            $display("tb_rotate_xor_decrypt_hint_matcher: FAIL");
        $finish;
    end

endmodule

/* rotate_xor_decrypt_hint_matcher.f */
+incdir+rtl
rtl/rxhm_pkg.sv
rtl/rxhm_if.sv
rtl/rxhm_cfg_regs.sv
rtl/rxhm_cell.sv
rtl/rotate_xor_decrypt_hint_matcher.sv
verif/tb_rotate_xor_decrypt_hint_matcher.sv
